// ===== rtl/prefix_code_bit_packer_macros.svh =====
// Assertion macros shared by the prefix code bit packer modules.
// Included by the controller and the datapath; no other dependencies.
`ifndef PREFIX_CODE_BIT_PACKER_MACROS_SVH
`define PREFIX_CODE_BIT_PACKER_MACROS_SVH
`ifndef SYNTH
`define PCBP_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");
`define PCBP_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define PCBP_ASSERT_IMP(lbl, clk, rst, a, b)
`define PCBP_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== rtl/pcbp_pkg.sv =====
// Package for the prefix code bit packer: defaults, command codes and the
// controller/datapath interface structs. No dependencies.
package pcbp_pkg;

  localparam int SYMBOLS_DEF = 256;
  localparam int CODE_WORDS_DEF = 4;
  localparam int WORD_BITS = 64;
  localparam int BYTE_BITS = 8;

  localparam logic [1:0] CMD_WR_CODE = 2'd0;
  localparam logic [1:0] CMD_WR_LEN  = 2'd1;
  localparam logic [1:0] CMD_ENCODE  = 2'd2;

  typedef struct packed {
    logic code_we;
    logic len_we;
    logic start;
    logic load;
    logic step;
    logic fetch;
    logic flush;
    logic count;
  } pcbp_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic last_step;
    logic word_end;
    logic last_sym;
    logic out_free;
  } pcbp_stat_t;

endpackage

// ===== rtl/pcbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pcbp_datapath.sv =====
// Datapath of the prefix code bit packer: code and length tables, code
// shift register, pending byte and output register. Uses pcbp_pkg and pcbp_ram.
`include "prefix_code_bit_packer_macros.svh"
module pcbp_datapath #(
  parameter int SYMBOLS = pcbp_pkg::SYMBOLS_DEF,
  parameter int CODE_WORDS = pcbp_pkg::CODE_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pcbp_pkg::pcbp_cmd_t ctrl,
  output pcbp_pkg::pcbp_stat_t stat,
  input  logic [7:0]          symbol,
  input  logic [1:0]          word_index,
  input  logic [63:0]         code_word,
  input  logic [7:0]          code_length,
  input  logic                last_symbol,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                is_pad_count,
  output logic                last
);
  import pcbp_pkg::*;

  localparam int CAW = $clog2(SYMBOLS * CODE_WORDS);
  localparam int LAW = $clog2(SYMBOLS);
  localparam logic [8:0] MAX_LEN = 9'(CODE_WORDS * WORD_BITS);

  logic        sym_in_range;
  logic        widx_in_range;
  logic        code_we;
  logic        len_we;
  logic        code_re;
  logic [CAW-1:0] code_waddr;
  logic [CAW-1:0] code_raddr;
  logic [7:0]  rd_sym;
  logic [1:0]  rd_widx;
  logic [63:0] code_q;
  logic [7:0]  len_q;
  logic [8:0]  len_sat;

  logic [7:0]  sym_reg;
  logic        sym_ok;
  logic        last_reg;
  logic [1:0]  widx;
  logic [8:0]  rem;
  logic [63:0] word_sr;
  logic [5:0]  bitpos;
  logic [7:0]  pending;
  logic [2:0]  pc;
  logic [3:0]  pad;

  logic [3:0]  avail_p;
  logic [6:0]  avail_w;
  logic [8:0]  t_pw;
  logic [8:0]  t_full;
  logic [3:0]  t;
  logic [7:0]  top_bits;
  logic [15:0] pend_wide;
  logic [7:0]  pend_next;
  logic [3:0]  pc_sum;
  logic        emit;
  logic        word_end;
  logic [7:0]  flush_byte;
  logic [3:0]  pad_next;
  logic        load_out;

  assign sym_in_range  = {1'b0, symbol} < 9'(SYMBOLS);
  assign widx_in_range = {1'b0, word_index} < 3'(CODE_WORDS);
  assign code_we = ctrl.code_we & sym_in_range & widx_in_range;
  assign len_we  = ctrl.len_we & sym_in_range;

  assign code_waddr = CAW'({2'b0, symbol} * 10'(CODE_WORDS) + {8'b0, word_index});
  assign rd_sym     = ctrl.start ? symbol : sym_reg;
  assign rd_widx    = ctrl.start ? 2'd0 : widx + 2'd1;
  assign code_raddr = CAW'({2'b0, rd_sym} * 10'(CODE_WORDS) + {8'b0, rd_widx});
  assign code_re    = ctrl.start | (ctrl.step & word_end);

  pcbp_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(SYMBOLS * CODE_WORDS)
  ) u_code_ram (
    .clk  (clk),
    .we   (code_we),
    .waddr(code_waddr),
    .wdata(code_word),
    .re   (code_re),
    .raddr(code_raddr),
    .rdata(code_q)
  );

  pcbp_ram #(
    .WIDTH(8),
    .DEPTH(SYMBOLS)
  ) u_len_ram (
    .clk  (clk),
    .we   (len_we),
    .waddr(symbol[LAW-1:0]),
    .wdata(code_length),
    .re   (ctrl.start),
    .raddr(symbol[LAW-1:0]),
    .rdata(len_q)
  );

  assign len_sat = ({1'b0, len_q} > MAX_LEN) ? MAX_LEN : {1'b0, len_q};

  // A step takes as many bits as fit in the pending byte, remain in the
  // code and remain in the current code word.
  assign avail_p   = 4'd8 - {1'b0, pc};
  assign avail_w   = 7'd64 - {1'b0, bitpos};
  assign t_pw      = ({5'b0, avail_p} < {2'b0, avail_w}) ? {5'b0, avail_p} : {2'b0, avail_w};
  assign t_full    = (rem < t_pw) ? rem : t_pw;
  assign t         = t_full[3:0];
  assign top_bits  = word_sr[63:56] >> (4'd8 - t);
  assign pend_wide = ({8'b0, pending} << t) | {8'b0, top_bits};
  assign pend_next = pend_wide[7:0];
  assign pc_sum    = {1'b0, pc} + t;
  assign emit      = pc_sum == 4'd8;
  assign word_end  = (({1'b0, bitpos} + {3'b0, t}) == 7'd64) && (rem != {5'b0, t});

  assign flush_byte = pending << (4'd8 - {1'b0, pc});
  assign pad_next   = (pc == 3'd0) ? 4'd0 : 4'd8 - {1'b0, pc};
  assign load_out   = (ctrl.step & emit) | (ctrl.flush & (pc != 3'd0)) | ctrl.count;

  assign stat.rem_zero  = rem == 9'd0;
  assign stat.last_step = rem == {5'b0, t};
  assign stat.word_end  = word_end;
  assign stat.last_sym  = last_reg;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 8'd0;
      pc        <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.step) begin
        pending <= emit ? 8'd0 : pend_next;
        pc      <= emit ? 3'd0 : pc_sum[2:0];
      end else if (ctrl.flush) begin
        pending <= 8'd0;
        pc      <= 3'd0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sym_reg  <= symbol;
      sym_ok   <= sym_in_range;
      last_reg <= last_symbol;
    end
    if (ctrl.load) begin
      rem     <= sym_ok ? len_sat : 9'd0;
      word_sr <= code_q;
      bitpos  <= 6'd0;
      widx    <= 2'd0;
    end else if (ctrl.fetch) begin
      word_sr <= code_q;
      bitpos  <= 6'd0;
      widx    <= widx + 2'd1;
    end else if (ctrl.step) begin
      rem     <= rem - {5'b0, t};
      word_sr <= word_sr << t;
      bitpos  <= bitpos + {2'b0, t};
    end
    if (ctrl.flush) begin
      pad <= pad_next;
    end
    if (ctrl.count) begin
      out_byte     <= {4'b0, pad};
      is_pad_count <= 1'b1;
      last         <= 1'b1;
    end else if (ctrl.flush) begin
      out_byte     <= flush_byte;
      is_pad_count <= 1'b0;
      last         <= 1'b0;
    end else if (ctrl.step) begin
      out_byte     <= pend_next;
      is_pad_count <= 1'b0;
      last         <= 1'b0;
    end
  end

  `PCBP_ASSERT_IMP(a_step_room, clk, rst, ctrl.step, stat.out_free)
  `PCBP_ASSERT_IMP(a_step_rem, clk, rst, ctrl.step, rem != 9'd0)
  `PCBP_ASSERT_NXT(a_count_clear, clk, rst, ctrl.count, pc == 3'd0)

endmodule

// ===== rtl/pcbp_controller.sv =====
// Controller state machine of the prefix code bit packer.
// Uses pcbp_pkg for command codes and the command and status structs.
`include "prefix_code_bit_packer_macros.svh"
module pcbp_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  pcbp_pkg::pcbp_stat_t stat,
  output pcbp_pkg::pcbp_cmd_t  ctrl
);
  import pcbp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_COUNT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          unique case (cmd)
            CMD_WR_CODE: ctrl.code_we = 1'b1;
            CMD_WR_LEN:  ctrl.len_we = 1'b1;
            CMD_ENCODE: begin
              ctrl.start = 1'b1;
              state_next = S_LOAD;
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        ctrl.load  = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        if (stat.rem_zero) begin
          state_next = stat.last_sym ? S_FLUSH : S_IDLE;
        end else if (stat.out_free) begin
          ctrl.step = 1'b1;
          if (stat.word_end) begin
            state_next = S_FETCH;
          end else if (stat.last_step) begin
            state_next = stat.last_sym ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_FETCH: begin
        ctrl.fetch = 1'b1;
        state_next = S_RUN;
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          ctrl.flush = 1'b1;
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        if (stat.out_free) begin
          ctrl.count = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PCBP_ASSERT_NXT(a_load_after_start, clk, rst, ctrl.start, state == S_LOAD)
  `PCBP_ASSERT_IMP(a_fetch_order, clk, rst, state == S_FETCH, $past(state) == S_RUN)

endmodule

// ===== rtl/prefix_code_bit_packer.sv =====
// Prefix code bit packer (static prefix code encoder).
// Input items write the code table or encode one byte; results are output bytes.
// Depends on pcbp_pkg, pcbp_controller and pcbp_datapath.
//
// The input channel carries commands: code word writes, code length writes
// and encode items. An encode item reads the symbol's length and first code
// word from RAM, then, while the output register is free, moves up to eight
// code bits a cycle into the pending byte, limited by free pending bits and
// the end of the current 64-bit code word. Crossing into the next code word
// takes a read of that word from the code RAM. A last item then flushes any
// pending bits as a final data byte and adds the padding count byte.
// Each completed byte is placed in an output register; the next input item
// is accepted while that byte still waits. When the receiver stalls, the
// packer holds its state and resumes when the output register frees up.
// Reset clears the pending bits and the state machine and holds off input;
// the code tables hold no valid data until written and need no clearing pass.
module prefix_code_bit_packer #(
  parameter int SYMBOLS = pcbp_pkg::SYMBOLS_DEF,
  parameter int CODE_WORDS = pcbp_pkg::CODE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  symbol,
  input  logic [1:0]  word_index,
  input  logic [63:0] code_word,
  input  logic [7:0]  code_length,
  input  logic        last_symbol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_pad_count,
  output logic        last
);
  import pcbp_pkg::*;

  pcbp_cmd_t  ctrl;
  pcbp_stat_t stat;

  pcbp_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  pcbp_datapath #(
    .SYMBOLS   (SYMBOLS),
    .CODE_WORDS(CODE_WORDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .symbol      (symbol),
    .word_index  (word_index),
    .code_word   (code_word),
    .code_length (code_length),
    .last_symbol (last_symbol),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .is_pad_count(is_pad_count),
    .last        (last)
  );

endmodule

// ===== dv/prefix_code_bit_packer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the prefix code bit packer: mirrors the code tables and the pending byte,
// predicts every output byte and compares each accepted byte with the oldest prediction.
// Depends on pcbp_pkg for the command codes and table sizes.
module prefix_code_bit_packer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  symbol,
  input  logic [1:0]  word_index,
  input  logic [63:0] code_word,
  input  logic [7:0]  code_length,
  input  logic        last_symbol,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        is_pad_count,
  input  logic        last,
  output int          owed_count,
  output int          fail_count
);
  import pcbp_pkg::*;

  localparam int MAX_LEN = CODE_WORDS_DEF * WORD_BITS;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       pad_count;
    logic       final_byte;
  } out_item_t;

  logic [63:0] code_table [SYMBOLS_DEF * CODE_WORDS_DEF];
  logic [7:0]  length_table [SYMBOLS_DEF];
  logic [7:0]  held_bits;
  int          held_count;
  int          byte_seq;
  out_item_t   owed_bytes [$];

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic flag);
    out_item_t item;
    item.data = data;
    item.pad_count = flag;
    item.final_byte = flag;
    owed_bytes.push_back(item);
  endtask

  task automatic pack_code_bits(input logic [7:0] sym, input logic final_sym);
    int len;
    int pad;
    logic [63:0] word;
    len = length_table[sym];
    if (len > MAX_LEN) len = MAX_LEN;
    for (int b = 0; b < len; b++) begin
      word = code_table[sym * CODE_WORDS_DEF + b / WORD_BITS];
      held_bits = {held_bits[6:0], word[WORD_BITS - 1 - b % WORD_BITS]};
      held_count++;
      if (held_count == BYTE_BITS) begin
        push_byte(held_bits, 1'b0);
        held_bits = '0;
        held_count = 0;
      end
    end
    if (final_sym) begin
      pad = 0;
      if (held_count != 0) begin
        pad = BYTE_BITS - held_count;
        push_byte(held_bits << pad, 1'b0);
      end
      push_byte(8'(pad), 1'b1);
      held_bits = '0;
      held_count = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      owed_bytes.delete();
      held_bits = '0;
      held_count = 0;
      byte_seq = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_bytes.size() == 0) begin
          report_mismatch($sformatf("output byte %0d (%02h) arrived with none predicted",
                                    byte_seq, out_byte));
        end else begin
          want = owed_bytes.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("output byte %0d: out_byte %02h, predicted %02h",
                                      byte_seq, out_byte, want.data));
          if (is_pad_count !== want.pad_count)
            report_mismatch($sformatf("output byte %0d: is_pad_count %b, predicted %b",
                                      byte_seq, is_pad_count, want.pad_count));
          if (last !== want.final_byte)
            report_mismatch($sformatf("output byte %0d: last %b, predicted %b",
                                      byte_seq, last, want.final_byte));
        end
        byte_seq++;
      end
      if (in_valid && in_ready) begin
        case (cmd)
          CMD_WR_CODE: code_table[symbol * CODE_WORDS_DEF + word_index] = code_word;
          CMD_WR_LEN: length_table[symbol] = code_length;
          CMD_ENCODE: pack_code_bits(symbol, last_symbol);
          default: ;
        endcase
      end
    end
    owed_count <= owed_bytes.size();
  end

endmodule

// ===== dv/tb_prefix_code_bit_packer.sv =====
`timescale 1ns / 1ps
// Top of the prefix code bit packer testbench: clock, reset, table loads, encode items
// and random stalls on both channels. Depends on pcbp_pkg, the packer and its checker.
module tb_prefix_code_bit_packer;
  import pcbp_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int ITEM_TARGET = 270;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_NONE;
  logic [7:0]  symbol = '0;
  logic [1:0]  word_index = '0;
  logic [63:0] code_word = '0;
  logic [7:0]  code_length = '0;
  logic        last_symbol = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        is_pad_count;
  logic        last;
  int          owed_count;
  int          fail_count;

  int         items_sent = 0;
  int         cycle_count = 0;
  bit         send_calm = 1'b0;
  bit [4:0]   written_mask [SYMBOLS_DEF];
  bit         is_ready [SYMBOLS_DEF];
  logic [7:0] ready_syms [$];

  prefix_code_bit_packer i_dut (.*);

  prefix_code_bit_packer_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int draw_wait(input bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'd0;
    if (r < 70) return 8'($urandom_range(1, 16));
    if (r < 90) return 8'($urandom_range(17, 64));
    return 8'($urandom_range(65, 255));
  endfunction

  task automatic send_item(input logic [1:0] c, input logic [7:0] sym, input logic [1:0] widx,
                           input logic [63:0] word, input logic [7:0] len, input logic fin);
    int gap;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    symbol <= sym;
    word_index <= widx;
    code_word <= word;
    code_length <= len;
    last_symbol <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c != CMD_NONE) items_sent++;
  endtask

  task automatic table_write(input logic [1:0] c, input logic [7:0] sym, input logic [1:0] widx,
                             input logic [63:0] word, input logic [7:0] len);
    int slot;
    send_item(c, sym, widx, word, len, 1'($urandom));
    slot = (c == CMD_WR_LEN) ? 4 : widx;
    written_mask[sym][slot] = 1'b1;
    if (written_mask[sym] == 5'h1F && !is_ready[sym]) begin
      is_ready[sym] = 1'b1;
      ready_syms.push_back(sym);
    end
  endtask

  task automatic load_symbol(input logic [7:0] sym, input logic [7:0] len,
                             input logic [255:0] code_bits);
    for (int w = 0; w < CODE_WORDS_DEF; w++)
      table_write(CMD_WR_CODE, sym, 2'(w), code_bits[255 - WORD_BITS * w -: 64], 8'($urandom));
    table_write(CMD_WR_LEN, sym, 2'($urandom), {$urandom, $urandom}, len);
  endtask

  task automatic encode_byte(input logic [7:0] sym, input logic fin);
    send_item(CMD_ENCODE, sym, 2'($urandom), {$urandom, $urandom}, 8'($urandom), fin);
  endtask

  initial begin : stimulus
    int r;
    logic [7:0] sym;
    logic [255:0] code_bits;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Table extremes: empty code, longest code, one-bit code and a code that
    // straddles a byte boundary.
    load_symbol(8'd0, 8'd0, '0);
    load_symbol(8'd255, 8'd255, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
                                 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A});
    load_symbol(8'd1, 8'd1, {1'b1, 255'd0});
    load_symbol(8'd170, 8'd9, {9'b1_0110_0101, 247'd0});

    // An empty code ending a message with nothing pending yields a zero count byte;
    // after pending bits it still flushes them.
    encode_byte(8'd0, 1'b1);
    encode_byte(8'd1, 1'b0);
    encode_byte(8'd170, 1'b0);
    encode_byte(8'd0, 1'b0);
    send_item(CMD_NONE, 8'hFF, 2'd3, '1, 8'hFF, 1'b1);
    encode_byte(8'd255, 1'b0);
    encode_byte(8'd0, 1'b1);
    encode_byte(8'd255, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        for (int k = 0; k < 8; k++) code_bits[32 * k +: 32] = $urandom;
        load_symbol(8'($urandom), pick_length(), code_bits);
      end else if (r < 14) begin
        sym = 8'($urandom);
        if ($urandom_range(0, 1) == 0)
          table_write(CMD_WR_LEN, sym, 2'($urandom), {$urandom, $urandom}, pick_length());
        else
          table_write(CMD_WR_CODE, sym, 2'($urandom), {$urandom, $urandom}, 8'($urandom));
      end else if (r < 17) begin
        send_item(CMD_NONE, 8'($urandom), 2'($urandom), {$urandom, $urandom}, 8'($urandom),
                  1'($urandom));
      end else begin
        encode_byte(ready_syms[$urandom_range(0, ready_syms.size() - 1)],
                    $urandom_range(0, 5) == 0);
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (owed_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : receiver
    int hold;
    int got;
    bit calm;
    got = 0;
    calm = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      hold = draw_wait(calm);
      // Long hold-offs let the output side back up into the input channel.
      if (got == 60 || got == 150) hold = HOLD_CYCLES;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got++;
    end
  end

endmodule

// ===== prefix_code_bit_packer.f =====
+incdir+rtl
rtl/pcbp_pkg.sv
rtl/pcbp_ram.sv
rtl/pcbp_datapath.sv
rtl/pcbp_controller.sv
rtl/prefix_code_bit_packer.sv
dv/prefix_code_bit_packer_checker.sv
dv/tb_prefix_code_bit_packer.sv
